// File: design/assert_macros.svh
// Assertion macros shared by the matrix inverse RTL.
// Each macro expects clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define M3I_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m3i assertion failed");

// Next-cycle implication, disabled during reset.
`define M3I_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m3i assertion failed");

`endif

// File: design/m3i_pkg.sv
// Package for the 3x3 matrix inverse: default widths and lane status type.
// Used by every module of the block.
package m3i_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Status one divider lane reports to the merge stage.
  typedef struct packed {
    logic sat;
    logic zero;
  } m3i_lane_flags_t;

endpackage

// File: design/m3i_cofactor.sv
// Cofactor stages: eighteen entry products, then the nine cofactor differences.
// Two register stages; depends on m3i_pkg.
module m3i_cofactor #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [DATA_WIDTH-1:0]   a      [9],
  output logic signed [2*DATA_WIDTH:0]   cof    [9],
  output logic signed [DATA_WIDTH-1:0]   row0   [3]
);
  import m3i_pkg::*;

  localparam int PW = 2 * DATA_WIDTH;
  localparam int CW = 2 * DATA_WIDTH + 1;

  logic signed [PW-1:0]         prod_p [9];
  logic signed [PW-1:0]         prod_q [9];
  logic signed [DATA_WIDTH-1:0] row0_d [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      localparam int U  = (i + 1) % 3;
      localparam int V  = (i + 2) % 3;
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          prod_p[i*3+k] <= PW'(a[U*3+K1]) * PW'(a[V*3+K2]);
          prod_q[i*3+k] <= PW'(a[U*3+K2]) * PW'(a[V*3+K1]);
          cof[i*3+k]    <= CW'(prod_p[i*3+k]) - CW'(prod_q[i*3+k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0_d <= '{a[0], a[1], a[2]};
      row0   <= row0_d;
    end
  end

endmodule

// File: design/m3i_det.sv
// Determinant stages: split products of cofactor row 0 with matrix row 0,
// term assembly, then the three-term sum. Carries cofactors alongside.
module m3i_det #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [2*DATA_WIDTH:0]     cof_in  [9],
  input  logic signed [DATA_WIDTH-1:0]     row0    [3],
  output logic signed [2*DATA_WIDTH:0]     cof_out [9],
  output logic signed [3*DATA_WIDTH+2:0]   det
);
  import m3i_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int HPW = 2 * DATA_WIDTH + 1;
  localparam int TW  = 3 * DATA_WIDTH + 1;
  localparam int DW  = 3 * DATA_WIDTH + 3;

  logic signed [HPW-1:0]      part_hi [3];
  logic signed [HPW-1:0]      part_lo [3];
  logic signed [TW-1:0]       term    [3];
  logic signed [2*DATA_WIDTH:0] cof_d1 [9];
  logic signed [2*DATA_WIDTH:0] cof_d2 [9];

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic signed [W:0] hi_part;
    logic signed [W:0] lo_part;
    assign hi_part = $signed(cof_in[k][2*W:W]);
    assign lo_part = $signed({1'b0, cof_in[k][W-1:0]});
    always_ff @(posedge clk) begin
      if (en) begin
        part_hi[k] <= HPW'(hi_part) * HPW'(row0[k]);
        part_lo[k] <= HPW'(lo_part) * HPW'(row0[k]);
        term[k]    <= (TW'(part_hi[k]) <<< W) + TW'(part_lo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det     <= DW'(term[0]) + DW'(term[1]) + DW'(term[2]);
      cof_d1  <= cof_in;
      cof_d2  <= cof_d1;
      cof_out <= cof_d2;
    end
  end

endmodule

// File: design/m3i_div_lane.sv
// One divider lane: restoring division of a shifted cofactor by the determinant,
// one quotient bit a stage, then sign and saturation. Depends on m3i_pkg.
module m3i_div_lane #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [2*DATA_WIDTH:0]     cof,
  input  logic signed [3*DATA_WIDTH+2:0]   det,
  output logic        [DATA_WIDTH-1:0]     value,
  output m3i_pkg::m3i_lane_flags_t         flags
);
  import m3i_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = 2 * DATA_WIDTH + 1;
  localparam int DW = 3 * DATA_WIDTH + 3;
  localparam int RW = CW + 2 * FRAC_BITS;
  localparam int XW = (RW > DW + W) ? RW : DW + W;

  logic [CW-1:0] num_mag;
  logic [DW-1:0] den_mag0;
  logic          sgn0;
  logic          zero0;

  logic [RW-1:0] rem  [W+1];
  logic [W-1:0]  quo  [W+1];
  logic [DW-1:0] den  [W+1];
  logic          sgn  [W+1];
  logic          big  [W+1];
  logic          zer  [W+1];

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      num_mag  <= cof[CW-1] ? CW'(~cof + 1'b1) : CW'(cof);
      den_mag0 <= det[DW-1] ? DW'(~det + 1'b1) : DW'(det);
      sgn0     <= cof[CW-1] ^ det[DW-1];
      zero0    <= (det == '0);
    end
  end

  // Quotient of 2^W or more saturates whatever its sign.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num_mag) << (2 * FRAC_BITS);
      quo[0] <= '0;
      den[0] <= den_mag0;
      sgn[0] <= sgn0;
      zer[0] <= zero0;
      big[0] <= ((XW'(num_mag) << (2 * FRAC_BITS)) >= (XW'(den_mag0) << W));
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_step
    localparam int B = W - 1 - s;
    logic [XW-1:0] trial;
    logic          fits;
    assign trial = XW'(den[s]) << B;
    assign fits  = (XW'(rem[s]) >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= fits ? RW'(XW'(rem[s]) - trial) : rem[s];
        quo[s+1] <= quo[s] | (W'(fits) << B);
        den[s+1] <= den[s];
        sgn[s+1] <= sgn[s];
        big[s+1] <= big[s];
        zer[s+1] <= zer[s];
      end
    end
  end

  logic [W-1:0] q;
  logic         pos_sat;
  logic         neg_sat;

  assign q       = quo[W];
  assign pos_sat = !sgn[W] && (big[W] || q[W-1]);
  assign neg_sat = sgn[W] && (big[W] || (q[W-1] && (|q[W-2:0])));

  always_comb begin
    if (zer[W]) begin
      value = '0;
    end else if (pos_sat) begin
      value = {1'b0, {(W-1){1'b1}}};
    end else if (neg_sat) begin
      value = {1'b1, {(W-1){1'b0}}};
    end else if (sgn[W]) begin
      value = ~q + 1'b1;
    end else begin
      value = q;
    end
    flags.zero = zer[W];
    flags.sat  = !zer[W] && (pos_sat || neg_sat);
  end

endmodule

// File: design/matrix3_inverse_top.sv
// 3x3 fixed-point matrix inverse by the adjugate, nine divider lanes wide.
// Uses m3i_pkg, m3i_cofactor, m3i_det, m3i_div_lane and assert_macros.svh.
//
// Usage: present a matrix a00..a22 (row-major, signed, FRAC_BITS fraction
// bits) with in_valid; a word is taken when in_valid and in_ready are high.
// The inverse b00..b22 comes out with out_valid and is taken when out_ready
// is high, together with singular (zero determinant, all entries zero) and
// overflow (some entry saturated).
// The pipeline has two cofactor stages, three determinant stages, two lane setup
// stages and one stage per quotient bit in each divider lane; the output register
// sits after the last lane stage.
// Throughput: one matrix per cycle unless the receiver stalls, set by the fully
// pipelined divider lanes.
// When the receiver stalls, the output word holds and the pipeline keeps
// moving until its last stage is full; then in_ready drops.
// Reset clears all valid bits; data registers are not reset.
module matrix3_inverse_top #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] a00,
  input  logic signed [DATA_WIDTH-1:0] a01,
  input  logic signed [DATA_WIDTH-1:0] a02,
  input  logic signed [DATA_WIDTH-1:0] a10,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] a12,
  input  logic signed [DATA_WIDTH-1:0] a20,
  input  logic signed [DATA_WIDTH-1:0] a21,
  input  logic signed [DATA_WIDTH-1:0] a22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] b00,
  output logic signed [DATA_WIDTH-1:0] b01,
  output logic signed [DATA_WIDTH-1:0] b02,
  output logic signed [DATA_WIDTH-1:0] b10,
  output logic signed [DATA_WIDTH-1:0] b11,
  output logic signed [DATA_WIDTH-1:0] b12,
  output logic signed [DATA_WIDTH-1:0] b20,
  output logic signed [DATA_WIDTH-1:0] b21,
  output logic signed [DATA_WIDTH-1:0] b22,
  output logic                         singular,
  output logic                         overflow
);
  import m3i_pkg::*;
`include "assert_macros.svh"

  localparam int DEPTH = DATA_WIDTH + 7;

  logic                           adv;
  logic [DEPTH-1:0]               vld;
  logic signed [DATA_WIDTH-1:0]   a_in   [9];
  logic signed [2*DATA_WIDTH:0]   cof    [9];
  logic signed [DATA_WIDTH-1:0]   row0   [3];
  logic signed [2*DATA_WIDTH:0]   cof_al [9];
  logic signed [3*DATA_WIDTH+2:0] det;
  logic [DATA_WIDTH-1:0]          lane_val   [9];
  m3i_lane_flags_t                lane_flags [9];
  logic [8:0]                     lane_sat;
  logic [DATA_WIDTH-1:0]          res [9];

  assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  // Advance while the last stage is empty or the output slot can take it.
  assign adv      = !vld[DEPTH-1] || !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        vld <= {vld[DEPTH-2:0], in_valid};
      end
      if (adv && vld[DEPTH-1]) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  m3i_cofactor #(.DATA_WIDTH(DATA_WIDTH)) u_cof (
    .clk  (clk),
    .en   (adv),
    .a    (a_in),
    .cof  (cof),
    .row0 (row0)
  );

  m3i_det #(.DATA_WIDTH(DATA_WIDTH)) u_det (
    .clk     (clk),
    .en      (adv),
    .cof_in  (cof),
    .row0    (row0),
    .cof_out (cof_al),
    .det     (det)
  );

  // Lane for b[i][j] divides the transposed cofactor c[j][i].
  for (genvar i = 0; i < 3; i++) begin : g_lane_row
    for (genvar j = 0; j < 3; j++) begin : g_lane_col
      m3i_div_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
        .clk   (clk),
        .en    (adv),
        .cof   (cof_al[j*3+i]),
        .det   (det),
        .value (lane_val[i*3+j]),
        .flags (lane_flags[i*3+j])
      );
      assign lane_sat[i*3+j] = lane_flags[i*3+j].sat;
    end
  end

  // Merge: capture the lane results, OR the lane saturation flags and take singular from lane 0.
  always_ff @(posedge clk) begin
    if (adv && vld[DEPTH-1]) begin
      res      <= lane_val;
      singular <= lane_flags[0].zero;
      overflow <= |lane_sat;
    end
  end

  assign b00 = res[0];
  assign b01 = res[1];
  assign b02 = res[2];
  assign b10 = res[3];
  assign b11 = res[4];
  assign b12 = res[5];
  assign b20 = res[6];
  assign b21 = res[7];
  assign b22 = res[8];

  `M3I_ASSERT_IMPL(a_sing_no_ovf, out_valid && singular, !overflow)
  `M3I_ASSERT_IMPL(a_sing_zero, out_valid && singular, b00 == '0 && b11 == '0 && b22 == '0)
  `M3I_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready && vld[DEPTH-1])
  `M3I_ASSERT_NEXT(a_out_loaded, adv && vld[DEPTH-1], out_valid)

endmodule
